>>> rtl/dtdiff_pkg.sv
// Shared widths, calendar tables and interface types for the date difference block.
`default_nettype none

package dtdiff_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DIFF_W   = 23;
   localparam int DAYNUM_W = 23;
   localparam int SUM_W    = DAYNUM_W + 1;
   localparam int YY_W     = YEAR_W + 1;
   localparam int Q100_W   = 8;
   localparam int R100_W   = 7;
   localparam int QUART_W  = YY_W - 2;
   localparam int PROD_W   = 29;
   localparam int DB_W     = 9;

   localparam logic [YY_W-1:0]     YEAR_OFFSET  = YY_W'(399);
   localparam logic [PROD_W-1:0]   RECIP_25     = PROD_W'(41944);
   localparam int                  RECIP_SHIFT  = 20;
   localparam logic [YY_W-1:0]     HUNDRED      = YY_W'(100);
   localparam logic [R100_W-1:0]   CENTURY_REM  = R100_W'(99);
   localparam logic [DAYNUM_W-1:0] DAYS_PER_YR  = DAYNUM_W'(365);
   localparam logic [DAY_W-1:0]    FEB_LEAP_LEN = DAY_W'(29);
   localparam logic [MONTH_W-1:0]  MONTH_JAN    = MONTH_W'(1);
   localparam logic [MONTH_W-1:0]  MONTH_FEB    = MONTH_W'(2);
   localparam logic [MONTH_W-1:0]  MONTH_DEC    = MONTH_W'(12);

   localparam logic signed [SUM_W-1:0] DIFF_MAX = SUM_W'(4194303);
   localparam logic signed [SUM_W-1:0] DIFF_MIN = -SUM_W'(4194304);

   // Indexed directly by the month number; codes outside 1 to 12 read zero.
   localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0};

   localparam logic [DB_W-1:0] DAYS_BEFORE [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0};

   typedef struct packed {
      logic                ok;
      logic [DAYNUM_W-1:0] day_num;
   } date_info_type;

   typedef struct packed {
      logic valid;
      logic include_end;
   } stage_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/dtdiff_date_unit.sv
// Two-stage conversion of one calendar date into a day number and a validity flag.
`default_nettype none

module dtdiff_date_unit (
   input  logic                          clock,
   input  logic [dtdiff_pkg::YEAR_W-1:0]  year,
   input  logic [dtdiff_pkg::MONTH_W-1:0] month,
   input  logic [dtdiff_pkg::DAY_W-1:0]   day,
   output dtdiff_pkg::date_info_type      info
);
   import dtdiff_pkg::*;

   logic [YY_W-1:0]     yy;
   logic [PROD_W-1:0]   prod;
   logic [DAYNUM_W-1:0] base_in;
   logic [YY_W-1:0]     yy_ff;
   logic [Q100_W-1:0]   q100_ff;
   logic [DAYNUM_W-1:0] base_ff;
   logic [MONTH_W-1:0]  month_ff;
   logic [DAY_W-1:0]    day_ff;

   logic [YY_W-1:0]     rem_full;
   logic [R100_W-1:0]   r100;
   logic                leap;
   logic [DAY_W-1:0]    len;
   logic                ok_in;
   logic [DAYNUM_W-1:0] num_in;
   date_info_type       info_ff;

   // The year divided by 100 is the quarter year divided by 25, by reciprocal.
   always_comb begin
      yy      = {1'b0, year} + YEAR_OFFSET;
      prod    = PROD_W'(yy[YY_W-1:2]) * RECIP_25;
      base_in = (DAYNUM_W'(yy) * DAYS_PER_YR) + DAYNUM_W'(yy[YY_W-1:2]);
   end

   always_ff @(posedge clock) begin
      yy_ff    <= yy;
      q100_ff  <= prod[RECIP_SHIFT+Q100_W-1:RECIP_SHIFT];
      base_ff  <= base_in;
      month_ff <= month;
      day_ff   <= day;
   end

   // The shifted year is 399 above the true one, so the leap test looks for
   // remainders of 3 modulo 4, 99 modulo 100 and 399 modulo 400.
   always_comb begin
      rem_full = yy_ff - (YY_W'(q100_ff) * HUNDRED);
      r100     = rem_full[R100_W-1:0];
      leap     = ((yy_ff[1:0] == 2'd3) && (r100 != CENTURY_REM)) ||
                 ((r100 == CENTURY_REM) && (q100_ff[1:0] == 2'd3));
      len      = MONTH_LEN[month_ff];
      if ((month_ff == MONTH_FEB) && leap) begin
         len = FEB_LEAP_LEN;
      end
      ok_in    = (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                 (day_ff != '0) && (day_ff <= len);
      num_in   = base_ff - DAYNUM_W'(q100_ff) + DAYNUM_W'(q100_ff[Q100_W-1:2]) +
                 DAYNUM_W'(DAYS_BEFORE[month_ff]) + DAYNUM_W'(day_ff) +
                 DAYNUM_W'((month_ff > MONTH_FEB) && leap);
   end

   always_ff @(posedge clock) begin
      info_ff.ok      <= ok_in;
      info_ff.day_num <= num_in;
   end

   assign info = info_ff;

endmodule

`default_nettype wire

>>> rtl/dtdiff_result.sv
// Signed difference of two day numbers with end-day adjustment, saturation and result register.
`default_nettype none

module dtdiff_result (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dtdiff_pkg::stage_ctrl_type              ctrl,
   input  dtdiff_pkg::date_info_type               first,
   input  dtdiff_pkg::date_info_type               second,
   output logic                                    rsp_valid,
   output logic signed [dtdiff_pkg::DIFF_W-1:0]    rsp_day_difference,
   output logic                                    rsp_bad_date
);
   import dtdiff_pkg::*;

   logic signed [SUM_W-1:0]  diff;
   logic signed [SUM_W-1:0]  adj;
   logic signed [SUM_W-1:0]  sat;
   logic                     bad_in;
   logic signed [DIFF_W-1:0] value_in;
   logic                     valid_ff;
   logic signed [DIFF_W-1:0] value_ff;
   logic                     bad_ff;

   always_comb begin
      diff = $signed({1'b0, second.day_num}) - $signed({1'b0, first.day_num});
      adj  = diff;
      if (ctrl.include_end) begin
         if (diff < 0) begin
            adj = diff - SUM_W'(1);
         end else begin
            adj = diff + SUM_W'(1);
         end
      end
      priority if (adj > DIFF_MAX) begin
         sat = DIFF_MAX;
      end else if (adj < DIFF_MIN) begin
         sat = DIFF_MIN;
      end else begin
         sat = adj;
      end
      bad_in   = !(first.ok && second.ok);
      value_in = bad_in ? '0 : sat[DIFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      bad_ff   <= bad_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_day_difference = value_ff;
   assign rsp_bad_date       = bad_ff;

endmodule

`default_nettype wire

>>> rtl/date_difference_in_days.sv
// Top level of the Gregorian date difference block: input register, date pipelines, result.
//
//   channel   handshake            payload
//   request   start, busy          req_first_*, req_second_*, req_include_end
//   response  rsp_valid (strobe)   rsp_day_difference, rsp_bad_date
//
// One transaction is taken in every cycle; busy stays low.
// The response strobe follows the accepting edge through the input register, the two
// date conversion stages and the result register, in that order.
// Reset clears the valid pipeline only; no transaction is in flight after it.
// The receiver cannot stall, so each response is shown for exactly one cycle.
`default_nettype none

module date_difference_in_days (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dtdiff_pkg::YEAR_W-1:0]        req_first_year,
   input  logic [dtdiff_pkg::MONTH_W-1:0]       req_first_month,
   input  logic [dtdiff_pkg::DAY_W-1:0]         req_first_day,
   input  logic [dtdiff_pkg::YEAR_W-1:0]        req_second_year,
   input  logic [dtdiff_pkg::MONTH_W-1:0]       req_second_month,
   input  logic [dtdiff_pkg::DAY_W-1:0]         req_second_day,
   input  logic                                 req_include_end,
   output logic                                 rsp_valid,
   output logic signed [dtdiff_pkg::DIFF_W-1:0] rsp_day_difference,
   output logic                                 rsp_bad_date
);
   import dtdiff_pkg::*;

   logic [YEAR_W-1:0]  first_year_ff;
   logic [MONTH_W-1:0] first_month_ff;
   logic [DAY_W-1:0]   first_day_ff;
   logic [YEAR_W-1:0]  second_year_ff;
   logic [MONTH_W-1:0] second_month_ff;
   logic [DAY_W-1:0]   second_day_ff;
   stage_ctrl_type     ctrl_in;
   stage_ctrl_type     ctrl0_ff;
   stage_ctrl_type     ctrl1_ff;
   stage_ctrl_type     ctrl2_ff;
   date_info_type      first_info;
   date_info_type      second_info;

   assign busy = 1'b0;

   always_comb begin
      ctrl_in.valid       = start && !busy;
      ctrl_in.include_end = req_include_end;
   end

   always_ff @(posedge clock) begin
      first_year_ff   <= req_first_year;
      first_month_ff  <= req_first_month;
      first_day_ff    <= req_first_day;
      second_year_ff  <= req_second_year;
      second_month_ff <= req_second_month;
      second_day_ff   <= req_second_day;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
         ctrl1_ff <= '0;
         ctrl2_ff <= '0;
      end else begin
         ctrl0_ff <= ctrl_in;
         ctrl1_ff <= ctrl0_ff;
         ctrl2_ff <= ctrl1_ff;
      end
   end

   dtdiff_date_unit u_first (
      .clock (clock),
      .year  (first_year_ff),
      .month (first_month_ff),
      .day   (first_day_ff),
      .info  (first_info)
   );

   dtdiff_date_unit u_second (
      .clock (clock),
      .year  (second_year_ff),
      .month (second_month_ff),
      .day   (second_day_ff),
      .info  (second_info)
   );

   dtdiff_result u_result (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl2_ff),
      .first              (first_info),
      .second             (second_info),
      .rsp_valid          (rsp_valid),
      .rsp_day_difference (rsp_day_difference),
      .rsp_bad_date       (rsp_bad_date)
   );

   a_bad_gives_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_date) |-> (rsp_day_difference == '0))
      else $error("Invalid date produced a nonzero difference.");

   a_strobe_follows_start : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 4))
      else $error("Response strobe without a matching request.");

   a_include_end_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_date && $past(req_include_end, 4))
         |-> (rsp_day_difference != '0))
      else $error("Inclusive count of a valid pair came out as zero.");

endmodule

`default_nettype wire
